FILE: hw/rtl/bcpd_pkg.sv
// Package for the battery compensated PWM duty block.
// Holds the field widths and fixed constants used by the top level.
// No dependencies.
package bcpd_pkg;

	localparam int DUTY_W = 8;
	localparam int REF_W  = 6;
	localparam int VCC_W  = 8;
	localparam int PSC_W  = 4;

	// Bandgap voltage in tenths of a volt.
	localparam int BANDGAP_X10 = 11;
	// Full scale of the normalized duty and of the compensated duty.
	localparam logic [VCC_W-1:0] DUTY_FULL = 8'd255;
	// Scaled reciprocal of the full-scale duty: (x * DUTY_FULL_RCP) >> DUTY_FULL_SHIFT
	// equals x / 255 rounded down for every x below 2^32.
	localparam logic [31:0] DUTY_FULL_RCP = 32'h8080_8081;
	localparam int DUTY_FULL_SHIFT = 39;
	// Saturation value of the supply voltage.
	localparam logic [VCC_W-1:0] VCC_SAT = 8'd255;
	// Reset value of the reference voltage register.
	localparam logic [REF_W-1:0] REF_RESET = 6'd42;

	// Width of the duty times reference product.
	localparam int PROD_W = DUTY_W + REF_W;

endpackage

FILE: hw/rtl/bcpd_div_cell.sv
// One cell of a restoring divider row: one quotient bit per cell.
// Used by bcpd_div_chain; no package dependencies.
module bcpd_div_cell #(
	parameter int NUM_W  = 14,
	parameter int DEN_W  = 8,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_ready,
	input  logic [DEN_W-1:0]  up_rem,
	input  logic [NUM_W-1:0]  up_numq,
	input  logic [DEN_W-1:0]  up_den,
	input  logic [SIDE_W-1:0] up_side,
	output logic              dn_valid,
	input  logic              dn_ready,
	output logic [DEN_W-1:0]  dn_rem,
	output logic [NUM_W-1:0]  dn_numq,
	output logic [DEN_W-1:0]  dn_den,
	output logic [SIDE_W-1:0] dn_side
);

	logic              valid_q;
	logic [DEN_W-1:0]  rem_q;
	logic [NUM_W-1:0]  numq_q;
	logic [DEN_W-1:0]  den_q;
	logic [SIDE_W-1:0] side_q;

	logic [DEN_W:0]    shifted;
	logic [DEN_W:0]    diff;
	logic              ge;
	logic [DEN_W-1:0]  rem_next;
	logic [NUM_W-1:0]  numq_next;

	// Bring down the next dividend bit and try to subtract the divisor. The quotient
	// bit shifts into the low end of the dividend register as its top bit leaves.
	always_comb begin
		shifted   = {up_rem, up_numq[NUM_W-1]};
		diff      = shifted - {1'b0, up_den};
		ge        = (shifted >= {1'b0, up_den});
		rem_next  = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
		numq_next = {up_numq[NUM_W-2:0], ge};
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			rem_q  <= rem_next;
			numq_q <= numq_next;
			den_q  <= up_den;
			side_q <= up_side;
		end
	end

	assign dn_valid = valid_q;
	assign dn_rem   = rem_q;
	assign dn_numq  = numq_q;
	assign dn_den   = den_q;
	assign dn_side  = side_q;

endmodule

FILE: hw/rtl/bcpd_div_chain.sv
// Row of bcpd_div_cell instances forming a pipelined unsigned divider.
// Depends on bcpd_div_cell; one cell per quotient bit.
module bcpd_div_chain #(
	parameter int NUM_W  = 14,
	parameter int DEN_W  = 8,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [NUM_W-1:0]  quo,
	output logic [DEN_W-1:0]  rem,
	output logic [SIDE_W-1:0] out_side
);

	logic [NUM_W:0]    valid_c;
	logic [NUM_W:0]    ready_c;
	logic [DEN_W-1:0]  rem_c  [NUM_W+1];
	logic [NUM_W-1:0]  numq_c [NUM_W+1];
	logic [DEN_W-1:0]  den_c  [NUM_W+1];
	logic [SIDE_W-1:0] side_c [NUM_W+1];

	assign valid_c[0] = in_valid;
	assign in_ready   = ready_c[0];
	assign rem_c[0]   = '0;
	assign numq_c[0]  = num;
	assign den_c[0]   = den;
	assign side_c[0]  = in_side;

	for (genvar i = 0; i < NUM_W; i++) begin : g_cell
		bcpd_div_cell #(
			.NUM_W  (NUM_W),
			.DEN_W  (DEN_W),
			.SIDE_W (SIDE_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (valid_c[i]),
			.up_ready (ready_c[i]),
			.up_rem   (rem_c[i]),
			.up_numq  (numq_c[i]),
			.up_den   (den_c[i]),
			.up_side  (side_c[i]),
			.dn_valid (valid_c[i+1]),
			.dn_ready (ready_c[i+1]),
			.dn_rem   (rem_c[i+1]),
			.dn_numq  (numq_c[i+1]),
			.dn_den   (den_c[i+1]),
			.dn_side  (side_c[i+1])
		);
	end

	assign ready_c[NUM_W] = out_ready;
	assign out_valid      = valid_c[NUM_W];
	assign quo            = numq_c[NUM_W];
	assign rem            = rem_c[NUM_W];
	assign out_side       = side_c[NUM_W];

endmodule

FILE: hw/rtl/battery_compensated_pwm_duty_top.sv
// Top level of the battery compensated PWM duty block.
// Depends on bcpd_pkg and on bcpd_div_chain (rows of bcpd_div_cell).
//
// Channel | Direction | Handshake          | Contents
// s_*     | in        | s_tvalid/s_tready  | one input item per accept
// m_*     | out       | m_tvalid/m_tready  | one result item per input item
// cfg_*   | in        | cfg_we             | reference_volts_x10 register
//
// Every stage is a cell with its own valid bit, so a new item is taken in every cycle
// unless every cell is full under a stalled output, and bubbles close up under a stalled
// output. The stages are ADC_BITS + 4 cells in the supply divider, 14 cells in the
// compensation divider, then the multiplier stage, the reciprocal stage that divides by
// 255 and the output register. Reset clears all valid bits and loads the reference with
// 42. A stall at m_tready ripples back through the cells; s_tready falls only once every cell is full.
module battery_compensated_pwm_duty_top #(
	parameter int ADC_BITS = 10,
	parameter int PWM_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,

	input  logic s_tvalid,
	output logic s_tready,
	// s_tdata, from bit 0 up: adc_reading, normalized_duty, pwm_top, prescale_code.
	input  logic [((ADC_BITS + PWM_BITS + bcpd_pkg::DUTY_W + bcpd_pkg::PSC_W + 7) / 8) * 8 - 1:0]
		s_tdata,

	output logic m_tvalid,
	input  logic m_tready,
	// m_tdata, from bit 0 up: vcc_x10, compare_match, pwm_enable, duty_clamped,
	// clock_select.
	output logic [((bcpd_pkg::VCC_W + PWM_BITS + 2 + bcpd_pkg::PSC_W + 7) / 8) * 8 - 1:0]
		m_tdata,

	input  logic                       cfg_we,
	input  logic [bcpd_pkg::REF_W-1:0] cfg_wdata
);

	import bcpd_pkg::*;

	localparam int OUT_W  = ((VCC_W + PWM_BITS + 2 + PSC_W + 7) / 8) * 8;
	localparam int OUT_F  = VCC_W + PWM_BITS + 2 + PSC_W;
	// The supply dividend 11 << ADC_BITS needs four bits above the ADC width.
	localparam int NUM1_W = ADC_BITS + 4;
	localparam logic [NUM1_W-1:0] NUM1 = NUM1_W'(BANDGAP_X10) << ADC_BITS;
	localparam int MUL_W  = PROD_W + PWM_BITS;
	localparam int RCP_W  = MUL_W + DUTY_FULL_SHIFT;
	localparam int SIDE1_W = PSC_W + PWM_BITS + PROD_W;
	localparam int SIDE2_W = PSC_W + PWM_BITS + VCC_W;

	// Configuration register.
	logic [REF_W-1:0] ref_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= REF_RESET;
		end else if (cfg_we) begin
			ref_q <= cfg_wdata;
		end
	end

	// Unpack the input item.
	logic [ADC_BITS-1:0] in_adc;
	logic [DUTY_W-1:0]   in_duty;
	logic [PWM_BITS-1:0] in_top;
	logic [PSC_W-1:0]    in_psc;
	logic [PROD_W-1:0]   in_prod;

	assign in_adc  = s_tdata[ADC_BITS-1:0];
	assign in_duty = s_tdata[ADC_BITS +: DUTY_W];
	assign in_top  = s_tdata[ADC_BITS + DUTY_W +: PWM_BITS];
	assign in_psc  = s_tdata[ADC_BITS + DUTY_W + PWM_BITS +: PSC_W];
	// The duty times reference product is small and rides along with the supply divide.
	assign in_prod = PROD_W'(in_duty) * PROD_W'(ref_q);

	// Supply voltage: (11 << ADC_BITS) / adc_reading. A zero reading produces an
	// all-ones quotient in the restoring divider and so saturates like a large one.
	logic                d1_valid;
	logic                d1_ready;
	logic [NUM1_W-1:0]   d1_quo;
	logic [ADC_BITS-1:0] d1_rem;
	logic [SIDE1_W-1:0]  d1_side;

	bcpd_div_chain #(
		.NUM_W  (NUM1_W),
		.DEN_W  (ADC_BITS),
		.SIDE_W (SIDE1_W)
	) u_div_vcc (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.num       (NUM1),
		.den       (in_adc),
		.in_side   ({in_psc, in_top, in_prod}),
		.out_valid (d1_valid),
		.out_ready (d1_ready),
		.quo       (d1_quo),
		.rem       (d1_rem),
		.out_side  (d1_side)
	);

	logic [VCC_W-1:0]    d1_vcc;
	logic [PROD_W-1:0]   d1_prod;
	logic [PWM_BITS-1:0] d1_top;
	logic [PSC_W-1:0]    d1_psc;

	assign {d1_psc, d1_top, d1_prod} = d1_side;
	// Anything above 255 saturates.
	assign d1_vcc = (|d1_quo[NUM1_W-1:VCC_W]) ? VCC_SAT : d1_quo[VCC_W-1:0];

	// Compensated duty: duty * reference / vcc. The supply is never zero here.
	logic               d2_valid;
	logic               d2_ready;
	logic [PROD_W-1:0]  d2_quo;
	logic [VCC_W-1:0]   d2_rem;
	logic [SIDE2_W-1:0] d2_side;

	bcpd_div_chain #(
		.NUM_W  (PROD_W),
		.DEN_W  (VCC_W),
		.SIDE_W (SIDE2_W)
	) u_div_adj (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (d1_valid),
		.in_ready  (d1_ready),
		.num       (d1_prod),
		.den       (d1_vcc),
		.in_side   ({d1_psc, d1_top, d1_vcc}),
		.out_valid (d2_valid),
		.out_ready (d2_ready),
		.quo       (d2_quo),
		.rem       (d2_rem),
		.out_side  (d2_side)
	);

	logic [PWM_BITS-1:0] d2_top;

	assign d2_top = d2_side[VCC_W +: PWM_BITS];

	// Multiplier stage: compensated duty times top, registered before the divide by 255.
	logic               mul_valid_s1;
	logic               mul_ready;
	logic [MUL_W-1:0]   mul_prod_s1;
	logic [SIDE2_W-1:0] mul_side_s1;
	logic               d3_ready;

	assign mul_ready = !mul_valid_s1 || d3_ready;
	assign d2_ready  = mul_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_valid_s1 <= 1'b0;
		end else if (mul_ready) begin
			mul_valid_s1 <= d2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (mul_ready && d2_valid) begin
			mul_prod_s1 <= MUL_W'(d2_quo) * MUL_W'(d2_top);
			mul_side_s1 <= d2_side;
		end
	end

	// Divide by the full-scale duty of 255 as a multiply by its scaled reciprocal. The
	// constant has only five set bits, so this is a short sum of shifted copies, and the
	// quotient is exact for every product below 2^32.
	logic               rcp_valid_s2;
	logic [MUL_W-1:0]   rcp_quo_s2;
	logic [SIDE2_W-1:0] rcp_side_s2;
	logic [RCP_W-1:0]   rcp_full;
	logic               d3_valid;
	logic               out_ready;
	logic [MUL_W-1:0]   d3_quo;
	logic [SIDE2_W-1:0] d3_side;

	assign rcp_full = RCP_W'(mul_prod_s1) * RCP_W'(DUTY_FULL_RCP);
	assign d3_ready = !rcp_valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcp_valid_s2 <= 1'b0;
		end else if (d3_ready) begin
			rcp_valid_s2 <= mul_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (d3_ready && mul_valid_s1) begin
			rcp_quo_s2  <= rcp_full[DUTY_FULL_SHIFT +: MUL_W];
			rcp_side_s2 <= mul_side_s1;
		end
	end

	assign d3_valid = rcp_valid_s2;
	assign d3_quo   = rcp_quo_s2;
	assign d3_side  = rcp_side_s2;

	logic [VCC_W-1:0]    d3_vcc;
	logic [PWM_BITS-1:0] d3_top;
	logic [PSC_W-1:0]    d3_psc;
	logic                d3_clamp;
	logic [PWM_BITS-1:0] d3_match;

	assign {d3_psc, d3_top, d3_vcc} = d3_side;

	// Clamp the match to top and flag it; a zero match turns the output off.
	always_comb begin
		d3_clamp = (d3_quo > MUL_W'(d3_top));
		d3_match = d3_clamp ? d3_top : d3_quo[PWM_BITS-1:0];
	end

	// Output register.
	logic             out_valid_s3;
	logic [OUT_F-1:0] out_data_s3;

	assign out_ready = !out_valid_s3 || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s3 <= 1'b0;
		end else if (out_ready) begin
			out_valid_s3 <= d3_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && d3_valid) begin
			out_data_s3 <= {d3_psc, d3_clamp, (d3_match != '0), d3_match, d3_vcc};
		end
	end

	assign m_tvalid = out_valid_s3;
	assign m_tdata  = OUT_W'(out_data_s3);

endmodule
